### hw/rtl/kaf_pkg.sv
// Shared constants, formats and saturation helpers of the angle/bias Kalman filter.
// No dependencies; imported by the top level, scoped names used by the serial units.
package kaf_pkg;

	// Field and state formats
	localparam int MEAS_W  = 25;   // Q9.16 measured angle
	localparam int GYRO_W  = 26;   // Q10.16 gyro rate
	localparam int DT_W    = 16;   // Q0.16 time step
	localparam int ANGLE_W = 32;   // Q16.16 angle and bias
	localparam int COV_W   = 48;   // Q16.32 covariance and gain
	localparam int CFG_W   = 24;   // Q8.16 noise settings
	localparam int Q_FRAC  = 16;   // fraction bits of Q16.16
	localparam int GAIN_FRAC = 32; // fraction bits of Q16.32

	// Exact sums before saturation, and rounded product magnitudes
	localparam int WORK_W = 52;
	localparam int MAG_W  = 65;

	// Serial units
	localparam int MUL_AW = COV_W;
	localparam int MUL_BW = COV_W;
	localparam int MUL_CW = $clog2(MUL_BW + 1);
	localparam int DIV_NW = COV_W;
	localparam int DIV_FW = GAIN_FRAC;
	localparam int DIV_QW = COV_W;

	// Multiplier run lengths (bits of the serial operand)
	localparam logic [MUL_CW-1:0] LEN_DT  = MUL_CW'(DT_W);
	localparam logic [MUL_CW-1:0] LEN_ERR = MUL_CW'(ANGLE_W);
	localparam logic [MUL_CW-1:0] LEN_COV = MUL_CW'(COV_W);

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;
	localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 24'd6554;
	localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 24'd19661;
	localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 24'd19661;

	function automatic logic signed [WORK_W-1:0] sx32(input logic signed [ANGLE_W-1:0] v);
		return {{(WORK_W-ANGLE_W){v[ANGLE_W-1]}}, v};
	endfunction

	function automatic logic signed [WORK_W-1:0] sx48(input logic signed [COV_W-1:0] v);
		return {{(WORK_W-COV_W){v[COV_W-1]}}, v};
	endfunction

	function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [WORK_W-1:0] v);
		if (v[WORK_W-1:ANGLE_W-1] == {(WORK_W-ANGLE_W+1){v[WORK_W-1]}})
			return v[ANGLE_W-1:0];
		else if (v[WORK_W-1])
			return {1'b1, {(ANGLE_W-1){1'b0}}};
		else
			return {1'b0, {(ANGLE_W-1){1'b1}}};
	endfunction

	function automatic logic signed [COV_W-1:0] sat48(input logic signed [WORK_W-1:0] v);
		if (v[WORK_W-1:COV_W-1] == {(WORK_W-COV_W+1){v[WORK_W-1]}})
			return v[COV_W-1:0];
		else if (v[WORK_W-1])
			return {1'b1, {(COV_W-1){1'b0}}};
		else
			return {1'b0, {(COV_W-1){1'b1}}};
	endfunction

	// Apply a sign to a magnitude and clip it to 32 bits
	function automatic logic signed [ANGLE_W-1:0] lim32(input logic neg,
		input logic [MAG_W-1:0] m);
		logic [ANGLE_W-1:0] low;
		low = m[ANGLE_W-1:0];
		if (m[MAG_W-1:ANGLE_W-1] != '0)
			return neg ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
		else
			return neg ? ~low + 1'b1 : low;
	endfunction

	// Apply a sign to a magnitude and clip it to 48 bits
	function automatic logic signed [COV_W-1:0] lim48(input logic neg,
		input logic [MAG_W-1:0] m);
		logic [COV_W-1:0] low;
		low = m[COV_W-1:0];
		if (m[MAG_W-1:COV_W-1] != '0)
			return neg ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
		else
			return neg ? ~low + 1'b1 : low;
	endfunction

	function automatic logic [COV_W-1:0] mag48(input logic signed [COV_W-1:0] v);
		return v[COV_W-1] ? COV_W'(-v) : COV_W'(v);
	endfunction

	function automatic logic [COV_W-1:0] mag32(input logic signed [ANGLE_W-1:0] v);
		logic [ANGLE_W-1:0] m;
		m = v[ANGLE_W-1] ? ANGLE_W'(-v) : ANGLE_W'(v);
		return COV_W'(m);
	endfunction

endpackage

### hw/rtl/kaf_serial_mul.sv
// Serial-parallel unsigned multiplier: one bit of the serial operand per cycle.
// Depends on kaf_pkg for default widths only.
module kaf_serial_mul #(
	parameter int AW = kaf_pkg::MUL_AW,
	parameter int BW = kaf_pkg::MUL_BW,
	localparam int CW = $clog2(BW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] len,
	input  logic [AW-1:0] mcand,
	input  logic [BW-1:0] mplier,
	output logic          done,
	output logic [AW-1:0] hi,
	output logic [BW-1:0] lo
);

	logic [AW-1:0] a_q;
	logic [AW-1:0] hi_q;
	logic [BW-1:0] b_q;
	logic [BW-1:0] lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [AW:0]   sum;

	// After len steps the product sits in {hi, top len bits of lo}
	assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= mcand;
			b_q  <= mplier;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum[AW:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
			b_q  <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign lo   = lo_q;

endmodule

### hw/rtl/kaf_serial_div.sv
// Restoring divider, one quotient bit per cycle: (num << FW) / den, sticky overflow.
// Depends on kaf_pkg for default widths only.
module kaf_serial_div #(
	parameter int NW = kaf_pkg::DIV_NW,
	parameter int FW = kaf_pkg::DIV_FW,
	parameter int QW = kaf_pkg::DIV_QW,
	localparam int DW = NW + FW,
	localparam int CW = $clog2(DW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo,
	output logic          over
);

	logic [DW-1:0] sh_q;
	logic [NW-1:0] den_q;
	logic [NW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic          over_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW:0]   trial;
	logic [NW:0]   diff;
	logic          ge;

	assign trial = {rem_q, sh_q[DW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= {num, {FW{1'b0}}};
			den_q  <= den;
			rem_q  <= '0;
			quo_q  <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			sh_q   <= sh_q << 1;
			rem_q  <= ge ? diff[NW-1:0] : trial[NW-1:0];
			quo_q  <= {quo_q[QW-2:0], ge};
			// flag any bit that leaves the quotient width
			over_q <= over_q | quo_q[QW-1];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign over = over_q;

endmodule

### hw/rtl/kalman_angle_filter.sv
// Two-state angle/bias Kalman filter, one filtered angle per transfer in.
// A new sample is taken only after the previous result has entered the output register. The
// item time is set by the 80-step gain divider (skipped when the innovation variance is zero)
// and the bit-serial multipliers (16, 16, 32, 48 and 48 steps in sequence).
// Reset (arst_n low, asynchronous): estimates and covariance clear to zero, noise settings
// return to 0.1, 0.3 and 0.3; the output register is emptied.
module kalman_angle_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [kaf_pkg::MEAS_W-1:0]    measured_angle,
	input  logic signed [kaf_pkg::GYRO_W-1:0]    gyro_rate,
	input  logic        [kaf_pkg::DT_W-1:0]      time_step,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [kaf_pkg::ANGLE_W-1:0]   filtered_angle,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [kaf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [kaf_pkg::CFG_W-1:0]     cfg_data
);

	import kaf_pkg::*;

	// Sequencer: one step of the filter per state or state pair. The *_GO states
	// launch the serial units, the *_WT states hold until they report done.
	typedef enum logic [4:0] {
		S_IDLE,
		S_PR1_GO,   // dt*rate and dt*P11
		S_PR1_WT,
		S_PR2,      // t - P01
		S_PR3,      // ... - P10
		S_PR4,      // ... + Qa, and the off-diagonal predict
		S_PR5_GO,   // dt*inner and dt*Qb
		S_PR5_WT,
		S_UP1,      // innovation variance and innovation
		S_DIV_GO,   // both gains
		S_DIV_WT,
		S_UP2_GO,   // gain times innovation
		S_UP2_WT,
		S_UP3_GO,   // bias row of the covariance
		S_UP3_WT,
		S_UP4_GO,   // angle row of the covariance
		S_UP4_WT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_load;

	// Noise settings
	logic [CFG_W-1:0] qa_q;
	logic [CFG_W-1:0] qb_q;
	logic [CFG_W-1:0] rm_q;

	// Filter state
	logic signed [ANGLE_W-1:0] ang_q;
	logic signed [ANGLE_W-1:0] bias_q;
	logic signed [COV_W-1:0]   p00_q;
	logic signed [COV_W-1:0]   p01_q;
	logic signed [COV_W-1:0]   p10_q;
	logic signed [COV_W-1:0]   p11_q;

	// Per-item working registers
	logic signed [MEAS_W-1:0]  meas_q;
	logic        [DT_W-1:0]    dt_q;
	logic signed [ANGLE_W-1:0] rate_q;
	logic signed [COV_W-1:0]   t_q;
	logic signed [WORK_W-1:0]  acc_q;
	logic signed [COV_W-1:0]   inner_q;
	logic signed [COV_W-1:0]   s_q;
	logic signed [ANGLE_W-1:0] y_q;
	logic signed [COV_W-1:0]   k0_q;
	logic signed [COV_W-1:0]   k1_q;
	logic signed [ANGLE_W-1:0] out_data_q;

	// Serial multipliers (shared start and length)
	logic                mul_start;
	logic [MUL_CW-1:0]   mul_len;
	logic [MUL_AW-1:0]   mula_a;
	logic [MUL_BW-1:0]   mula_b;
	logic [MUL_AW-1:0]   mulb_a;
	logic [MUL_BW-1:0]   mulb_b;
	logic                mula_done;
	logic                mulb_done;
	logic [MUL_AW-1:0]   mula_hi;
	logic [MUL_BW-1:0]   mula_lo;
	logic [MUL_AW-1:0]   mulb_hi;
	logic [MUL_BW-1:0]   mulb_lo;
	logic                mul_done;

	// Serial dividers (gains share the denominator)
	logic                div_start;
	logic                diva_done;
	logic                divb_done;
	logic [DIV_QW-1:0]   diva_quo;
	logic [DIV_QW-1:0]   divb_quo;
	logic                diva_over;
	logic                divb_over;
	logic                div_done;

	// Rounded product magnitudes. A run of n steps with shift n leaves the
	// integer part in hi and the rounding bit at the top of lo; the 48-step
	// gain products shift by 32 instead.
	logic [MAG_W-1:0]    rnd_a_n;
	logic [MAG_W-1:0]    rnd_b_n;
	logic [MAG_W-1:0]    rnd_a_w;
	logic [MAG_W-1:0]    rnd_b_w;
	logic [WORK_W-1:0]   exact_b;

	assign rnd_a_n = MAG_W'({1'b0, mula_hi}) + MAG_W'(mula_lo[MUL_BW-1]);
	assign rnd_b_n = MAG_W'({1'b0, mulb_hi}) + MAG_W'(mulb_lo[MUL_BW-1]);
	assign rnd_a_w = MAG_W'({mula_hi, mula_lo[MUL_BW-1:GAIN_FRAC]})
		+ MAG_W'(mula_lo[GAIN_FRAC-1]);
	assign rnd_b_w = MAG_W'({mulb_hi, mulb_lo[MUL_BW-1:GAIN_FRAC]})
		+ MAG_W'(mulb_lo[GAIN_FRAC-1]);
	// dt*Qb is exact: no shift, fits well inside the working width
	assign exact_b = WORK_W'({mulb_hi, mulb_lo[MUL_BW-1:MUL_BW-DT_W]});

	assign mul_done = mula_done & mulb_done;
	assign div_done = diva_done & divb_done;

	// Operand selection for the multipliers
	always_comb begin
		mul_start = 1'b0;
		mul_len   = LEN_DT;
		mula_a    = '0;
		mula_b    = '0;
		mulb_a    = '0;
		mulb_b    = '0;
		unique case (state_q)
			S_PR1_GO: begin
				mul_start = 1'b1;
				mula_a    = mag32(rate_q);
				mula_b    = MUL_BW'(dt_q);
				mulb_a    = mag48(p11_q);
				mulb_b    = MUL_BW'(dt_q);
			end
			S_PR5_GO: begin
				mul_start = 1'b1;
				mula_a    = mag48(inner_q);
				mula_b    = MUL_BW'(dt_q);
				mulb_a    = MUL_AW'(qb_q);
				mulb_b    = MUL_BW'(dt_q);
			end
			S_UP2_GO: begin
				mul_start = 1'b1;
				mul_len   = LEN_ERR;
				mula_a    = mag48(k0_q);
				mula_b    = mag32(y_q);
				mulb_a    = mag48(k1_q);
				mulb_b    = mag32(y_q);
			end
			S_UP3_GO: begin
				mul_start = 1'b1;
				mul_len   = LEN_COV;
				mula_a    = mag48(k1_q);
				mula_b    = mag48(p00_q);
				mulb_a    = mag48(k1_q);
				mulb_b    = mag48(p01_q);
			end
			S_UP4_GO: begin
				mul_start = 1'b1;
				mul_len   = LEN_COV;
				mula_a    = mag48(k0_q);
				mula_b    = mag48(p00_q);
				mulb_a    = mag48(k0_q);
				mulb_b    = mag48(p01_q);
			end
			default: begin
			end
		endcase
	end

	// Skip the dividers when the innovation variance is zero: gains are zero
	assign div_start = (state_q == S_DIV_GO) && (s_q != '0);

	kaf_serial_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.len    (mul_len),
		.mcand  (mula_a),
		.mplier (mula_b),
		.done   (mula_done),
		.hi     (mula_hi),
		.lo     (mula_lo)
	);

	kaf_serial_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.len    (mul_len),
		.mcand  (mulb_a),
		.mplier (mulb_b),
		.done   (mulb_done),
		.hi     (mulb_hi),
		.lo     (mulb_lo)
	);

	kaf_serial_div #(.NW(DIV_NW), .FW(DIV_FW), .QW(DIV_QW)) u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag48(p00_q)),
		.den    (mag48(s_q)),
		.done   (diva_done),
		.quo    (diva_quo),
		.over   (diva_over)
	);

	kaf_serial_div #(.NW(DIV_NW), .FW(DIV_FW), .QW(DIV_QW)) u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag48(p10_q)),
		.den    (mag48(s_q)),
		.done   (divb_done),
		.quo    (divb_quo),
		.over   (divb_over)
	);

	// Load the output register once it is empty or being drained this cycle
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// fill on a load, otherwise hold only while the result is stalled
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_PR1_GO;
				S_PR1_GO: state_q <= S_PR1_WT;
				S_PR1_WT: if (mul_done) state_q <= S_PR2;
				S_PR2:    state_q <= S_PR3;
				S_PR3:    state_q <= S_PR4;
				S_PR4:    state_q <= S_PR5_GO;
				S_PR5_GO: state_q <= S_PR5_WT;
				S_PR5_WT: if (mul_done) state_q <= S_UP1;
				S_UP1:    state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= (s_q == '0) ? S_UP2_GO : S_DIV_WT;
				S_DIV_WT: if (div_done) state_q <= S_UP2_GO;
				S_UP2_GO: state_q <= S_UP2_WT;
				S_UP2_WT: if (mul_done) state_q <= S_UP3_GO;
				S_UP3_GO: state_q <= S_UP3_WT;
				S_UP3_WT: if (mul_done) state_q <= S_UP4_GO;
				S_UP4_GO: state_q <= S_UP4_WT;
				S_UP4_WT: if (mul_done) state_q <= S_DONE;
				S_DONE:   if (out_load) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Noise settings: always ready, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= ANGLE_NOISE_RST;
			qb_q <= BIAS_NOISE_RST;
			rm_q <= MEAS_NOISE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ANGLE_NOISE: qa_q <= cfg_data;
				CFG_BIAS_NOISE:  qb_q <= cfg_data;
				CFG_MEAS_NOISE:  rm_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Filter state: every write saturates to the destination width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= '0;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= '0;
		end else begin
			unique case (state_q)
				S_PR1_WT: begin
					// predicted angle: add the integrated bias-corrected rate
					if (mul_done)
						ang_q <= sat32(sx32(ang_q) + sx32(lim32(rate_q[ANGLE_W-1], rnd_a_n)));
				end
				S_PR4: begin
					p01_q <= sat48(sx48(p01_q) - sx48(t_q));
					p10_q <= sat48(sx48(p10_q) - sx48(t_q));
				end
				S_PR5_WT: begin
					if (mul_done) begin
						p00_q <= sat48(sx48(p00_q)
							+ sx48(lim48(inner_q[COV_W-1], rnd_a_n)));
						p11_q <= sat48(sx48(p11_q) + exact_b);
					end
				end
				S_UP2_WT: begin
					// correct angle and bias with the innovation
					if (mul_done) begin
						ang_q  <= sat32(sx32(ang_q)
							+ sx32(lim32(k0_q[COV_W-1] ^ y_q[ANGLE_W-1], rnd_a_n)));
						bias_q <= sat32(sx32(bias_q)
							+ sx32(lim32(k1_q[COV_W-1] ^ y_q[ANGLE_W-1], rnd_b_n)));
					end
				end
				S_UP3_WT: begin
					// bias row first, so it still reads the predicted P00 and P01 before the angle row updates them
					if (mul_done) begin
						p10_q <= sat48(sx48(p10_q)
							- sx48(lim48(k1_q[COV_W-1] ^ p00_q[COV_W-1], rnd_a_w)));
						p11_q <= sat48(sx48(p11_q)
							- sx48(lim48(k1_q[COV_W-1] ^ p01_q[COV_W-1], rnd_b_w)));
					end
				end
				S_UP4_WT: begin
					if (mul_done) begin
						p00_q <= sat48(sx48(p00_q)
							- sx48(lim48(k0_q[COV_W-1] ^ p00_q[COV_W-1], rnd_a_w)));
						p01_q <= sat48(sx48(p01_q)
							- sx48(lim48(k0_q[COV_W-1] ^ p01_q[COV_W-1], rnd_b_w)));
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Per-item working values
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				// capture the sample on its transfer
				if (in_valid) begin
					meas_q <= measured_angle;
					dt_q   <= time_step;
					rate_q <= sat32({{(WORK_W-GYRO_W){gyro_rate[GYRO_W-1]}}, gyro_rate}
						- sx32(bias_q));
				end
			end
			S_PR1_WT: begin
				if (mul_done)
					t_q <= lim48(p11_q[COV_W-1], rnd_b_n);
			end
			// inner = t - P01 - P10 + Qa, formed exactly, one term a cycle
			S_PR2: acc_q <= sx48(t_q) - sx48(p01_q);
			S_PR3: acc_q <= acc_q - sx48(p10_q);
			S_PR4: inner_q <= sat48(acc_q + WORK_W'({qa_q, {Q_FRAC{1'b0}}}));
			S_UP1: begin
				s_q <= sat48(sx48(p00_q) + WORK_W'({rm_q, {Q_FRAC{1'b0}}}));
				y_q <= sat32({{(WORK_W-MEAS_W){meas_q[MEAS_W-1]}}, meas_q} - sx32(ang_q));
			end
			S_DIV_GO: begin
				if (s_q == '0) begin
					k0_q <= '0;
					k1_q <= '0;
				end
			end
			S_DIV_WT: begin
				if (div_done) begin
					k0_q <= lim48(p00_q[COV_W-1] ^ s_q[COV_W-1],
						MAG_W'({diva_over, diva_quo}));
					k1_q <= lim48(p10_q[COV_W-1] ^ s_q[COV_W-1],
						MAG_W'({divb_over, divb_quo}));
				end
			end
			S_DONE: begin
				if (out_load)
					out_data_q <= ang_q;
			end
			default: begin
			end
		endcase
	end

	// Take a new sample only between items. The output register decouples the result channel:
	// a held result lets one more item in, which then waits in S_DONE until the result drains.
	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign filtered_angle = out_data_q;
	assign cfg_ready      = 1'b1;

endmodule

### tb/kalman_angle_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for kalman_angle_filter: random gaps and stalls, checks every angle.
// Depends on kaf_pkg and the filter RTL; its own fixed-point Kalman predictor supplies the
// expected angles.
module kalman_angle_filter_tb;
	import kaf_pkg::*;

	localparam int MEAS_LIM       = 11796480;   // +-180 degrees in Q9.16
	localparam int RATE_LIM       = 32768000;   // +-500 deg/s in Q10.16
	localparam int DT_MAX         = 65535;
	localparam logic [CFG_W-1:0] CFG_MAX = '1;
	localparam int WATCHDOG_LIMIT = 5000;       // idle cycles
	localparam int DRAIN_CYCLES   = 300;

	typedef logic signed [127:0] wide_t;
	typedef logic [127:0] ubig_t;

	typedef struct {
		logic signed [MEAS_W-1:0] angle;
		logic signed [GYRO_W-1:0] rate;
		logic [DT_W-1:0]          step;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [MEAS_W-1:0]    measured_angle = '0;
	logic signed [GYRO_W-1:0]    gyro_rate = '0;
	logic [DT_W-1:0]             time_step = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [ANGLE_W-1:0]   filtered_angle;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]            cfg_data = '0;

	kalman_angle_filter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.measured_angle (measured_angle),
		.gyro_rate      (gyro_rate),
		.time_step      (time_step),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_angle (filtered_angle),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Filter predictor: angle, bias and the 2x2 covariance, held wide so
	// every intermediate is exact before it is clipped to its format.
	// ------------------------------------------------------------------
	wide_t est_angle = '0, est_bias = '0;
	wide_t p_aa = '0, p_ab = '0, p_ba = '0, p_bb = '0;
	wide_t noise_angle = wide_t'(ANGLE_NOISE_RST);
	wide_t noise_bias  = wide_t'(BIAS_NOISE_RST);
	wide_t noise_meas  = wide_t'(MEAS_NOISE_RST);

	// Clip a signed value to w bits
	function automatic wide_t clip(wide_t v, int w);
		wide_t top;
		top = (wide_t'(1) <<< (w - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	function automatic ubig_t magnitude(wide_t v);
		return (v < 0) ? ubig_t'(-v) : ubig_t'(v);
	endfunction

	// Put the sign back on a magnitude, clipping it to w bits
	function automatic wide_t apply_sign(logic neg, ubig_t m, int w);
		ubig_t lim;
		lim = ubig_t'(1) << (w - 1);
		if (neg)
			return (m >= lim) ? -wide_t'(lim) : -wide_t'(m);
		return (m >= lim) ? wide_t'(lim - 1) : wide_t'(m);
	endfunction

	// (a * b) >> s, nearest with ties away from zero, clipped to w bits
	function automatic wide_t mul_round(wide_t a, wide_t b, int s, int w);
		ubig_t p;
		p = magnitude(a) * magnitude(b) + (ubig_t'(1) << (s - 1));
		return apply_sign((a < 0) != (b < 0), p >> s, w);
	endfunction

	// Q16.32 gain n / d, truncated toward zero; zero when d is zero
	function automatic wide_t gain_of(wide_t n, wide_t d);
		if (d == 0)
			return '0;
		return apply_sign((n < 0) != (d < 0), (magnitude(n) << GAIN_FRAC) / magnitude(d), COV_W);
	endfunction

	// Run predict and update for one sample; return the new angle
	function automatic logic signed [ANGLE_W-1:0] kalman_update(
		logic signed [MEAS_W-1:0] angle_in,
		logic signed [GYRO_W-1:0] rate_in,
		logic [DT_W-1:0] step_in);
		wide_t meas, gyro, dt, rate, t, inner, s, k0, k1, y, p00t, p01t;
		meas = wide_t'(angle_in);
		gyro = wide_t'(rate_in);
		dt   = wide_t'(step_in);

		// predict
		rate      = clip(gyro - est_bias, ANGLE_W);
		est_angle = clip(est_angle + mul_round(dt, rate, Q_FRAC, ANGLE_W), ANGLE_W);
		t     = mul_round(dt, p_bb, Q_FRAC, COV_W);
		inner = clip(t - p_ab - p_ba + (noise_angle <<< Q_FRAC), COV_W);
		p_aa  = clip(p_aa + mul_round(dt, inner, Q_FRAC, COV_W), COV_W);
		p_ab  = clip(p_ab - t, COV_W);
		p_ba  = clip(p_ba - t, COV_W);
		p_bb  = clip(p_bb + dt * noise_bias, COV_W);

		// update; a zero innovation variance leaves both gains at zero
		s  = clip(p_aa + (noise_meas <<< Q_FRAC), COV_W);
		k0 = gain_of(p_aa, s);
		k1 = gain_of(p_ba, s);
		y  = clip(meas - est_angle, ANGLE_W);
		est_angle = clip(est_angle + mul_round(k0, y, GAIN_FRAC, ANGLE_W), ANGLE_W);
		est_bias  = clip(est_bias + mul_round(k1, y, GAIN_FRAC, ANGLE_W), ANGLE_W);
		p00t = p_aa;
		p01t = p_ab;
		p_aa = clip(p_aa - mul_round(k0, p00t, GAIN_FRAC, COV_W), COV_W);
		p_ab = clip(p_ab - mul_round(k0, p01t, GAIN_FRAC, COV_W), COV_W);
		p_ba = clip(p_ba - mul_round(k1, p00t, GAIN_FRAC, COV_W), COV_W);
		p_bb = clip(p_bb - mul_round(k1, p01t, GAIN_FRAC, COV_W), COV_W);
		return est_angle[ANGLE_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Sample driver: pop pending samples, insert random gaps, and hold
	// the payload steady while the filter stalls.
	// ------------------------------------------------------------------
	sample_t pending_samples[$];
	logic signed [ANGLE_W-1:0] expected_angles[$];
	int samples_queued = 0;
	int angles_checked = 0;
	int mismatch_count = 0;

	sample_t next_sample;
	int gap_left = 0;
	int send_roll;
	bit send_steady = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				// transfer accepted: predict its angle from the payload on the port
				expected_angles.push_back(kalman_update(measured_angle, gyro_rate, time_step));
				send_roll = $urandom_range(99);
				if ($urandom_range(39) == 0)
					send_steady = !send_steady;
				if (send_steady || send_roll < 55)
					gap_left = 0;
				else if (send_roll < 88)
					gap_left = $urandom_range(4, 1);
				else if (send_roll < 98)
					gap_left = $urandom_range(30, 5);
				else
					gap_left = $urandom_range(400, 100);
			end
			// advance only when the port is empty or its transfer just went through
			if (!in_valid || !in_stall) begin
				if (gap_left != 0 || pending_samples.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					next_sample = pending_samples.pop_front();
					measured_angle <= next_sample.angle;
					gyro_rate      <= next_sample.rate;
					time_step      <= next_sample.step;
					in_valid       <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random stalls, in-order compare of every angle.
	// ------------------------------------------------------------------
	int stall_left = 0;
	int recv_roll;
	bit recv_steady = 1'b0;

	task automatic note_mismatch(string what, logic signed [ANGLE_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected %0d, got %0d", $time, what, want, filtered_angle);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				angles_checked++;
				if (expected_angles.size() == 0)
					note_mismatch("filtered_angle with no sample outstanding", 'x);
				else if (filtered_angle !== expected_angles[0]) begin
					note_mismatch("filtered_angle mismatch", expected_angles[0]);
					void'(expected_angles.pop_front());
				end else
					void'(expected_angles.pop_front());
			end
			// stalls: mostly from the shortest range, now and then a long one
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!recv_steady && $urandom_range(4) == 0) begin
				recv_roll = $urandom_range(99);
				if (recv_roll < 85)
					stall_left = $urandom_range(3);
				else if (recv_roll < 97)
					stall_left = $urandom_range(40, 4);
				else
					stall_left = $urandom_range(300, 50);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
			if ($urandom_range(999) == 0)
				recv_steady = !recv_steady;
		end
	end

	// Watchdog: end the run when no transfer of any kind happens for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL kalman_angle_filter");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ANGLE_NOISE: noise_angle = wide_t'(value);
			CFG_BIAS_NOISE:  noise_bias  = wide_t'(value);
			CFG_MEAS_NOISE:  noise_meas  = wide_t'(value);
			default: ;
		endcase
	endtask

	task automatic set_noise(logic [CFG_W-1:0] qa, logic [CFG_W-1:0] qb, logic [CFG_W-1:0] r);
		write_reg(CFG_ANGLE_NOISE, qa);
		write_reg(CFG_BIAS_NOISE, qb);
		write_reg(CFG_MEAS_NOISE, r);
	endtask

	// Hold until every queued sample has come back as an angle
	task automatic wait_drained();
		do
			@(posedge clk);
		while (angles_checked < samples_queued);
	endtask

	task automatic push_sample(int angle, int rate, int step);
		sample_t s;
		s.angle = MEAS_W'(angle);
		s.rate  = GYRO_W'(rate);
		s.step  = DT_W'(step);
		pending_samples.push_back(s);
		samples_queued++;
	endtask

	// Mostly in the sensor range; some full-width noise and rail values
	function automatic int field_value(int lim, int w);
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return int'($urandom_range(2 * lim)) - lim;
		if (r < 95)
			return int'($urandom) >>> (32 - w);
		case ($urandom_range(3))
			0: return lim;
			1: return -lim;
			2: return (1 << (w - 1)) - 1;
			default: return -(1 << (w - 1));
		endcase
	endfunction

	task automatic push_random_sample();
		int r, step;
		r = $urandom_range(99);
		if (r < 60)
			step = $urandom_range(1500, 40);    // millisecond-scale steps
		else if (r < 90)
			step = $urandom_range(DT_MAX);
		else
			step = ($urandom_range(1) == 0) ? 0 : DT_MAX;
		push_sample(field_value(MEAS_LIM, MEAS_W), field_value(RATE_LIM, GYRO_W), step);
	endtask

	function automatic logic [CFG_W-1:0] rand_noise();
		int r;
		r = $urandom_range(9);
		if (r < 2)
			return '0;
		if (r < 4)
			return CFG_MAX;
		return CFG_W'($urandom_range(CFG_MAX));
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// All noise zero with the covariance still clear from reset: the innovation
		// variance is zero, both gains stay zero and the angle just integrates the gyro.
		set_noise('0, '0, '0);
		push_sample(0, 0, 0);
		push_sample(MEAS_LIM, 0, DT_MAX);
		push_sample(-MEAS_LIM, RATE_LIM, 1);
		push_sample((1 << (MEAS_W - 1)) - 1, -RATE_LIM, DT_MAX);
		push_sample(-(1 << (MEAS_W - 1)), (1 << (GYRO_W - 1)) - 1, 0);
		push_sample(0, -(1 << (GYRO_W - 1)), DT_MAX);
		push_sample(5, 100, 65);
		// drive the angle into the positive rail, then all the way to the negative one
		repeat (70)
			push_sample(field_value(MEAS_LIM, MEAS_W), (1 << (GYRO_W - 1)) - 1, DT_MAX);
		repeat (140)
			push_sample(field_value(MEAS_LIM, MEAS_W), -(1 << (GYRO_W - 1)), DT_MAX);
		wait_drained();

		// Power-on noise settings: step responses and rail inputs
		set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
		push_sample(0, 0, 655);
		push_sample(MEAS_LIM, 0, 655);
		push_sample(-MEAS_LIM, 1000000, DT_MAX);
		push_sample((1 << (MEAS_W - 1)) - 1, (1 << (GYRO_W - 1)) - 1, DT_MAX);
		push_sample(-(1 << (MEAS_W - 1)), -(1 << (GYRO_W - 1)), DT_MAX);
		push_sample(0, 0, 0);
		push_sample(100, -100, 1);
		push_sample(MEAS_LIM, -RATE_LIM, 40000);
		wait_drained();

		// Random phases; the first few pin the noise settings to their extremes.
		// With zero measurement noise the covariance can collapse to zero, so the
		// zero innovation variance case comes back with a live state.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_noise(CFG_MAX, CFG_MAX, CFG_MAX);
				1: set_noise('0, '0, CFG_MAX);
				2: set_noise(CFG_MAX, '0, '0);
				3: set_noise(CFG_W'(1), CFG_W'(1), CFG_W'(1));
				default: set_noise(rand_noise(), rand_noise(), rand_noise());
			endcase
			repeat (80)
				push_random_sample();
			wait_drained();
		end

		// drain: catch any stray result the filter might still produce
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS kalman_angle_filter");
		else
			$display("FAIL kalman_angle_filter");
		$finish;
	end

endmodule

### kalman_angle_filter.f
hw/rtl/kaf_pkg.sv
hw/rtl/kaf_serial_mul.sv
hw/rtl/kaf_serial_div.sv
hw/rtl/kalman_angle_filter.sv
tb/kalman_angle_filter_tb.sv
